// ===== sv/gtr_pkg.sv =====
// Shared types, constants and font tables of the glyph text renderer.
package gtr_pkg;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_GLYPH = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_FONT_SIZE  = 2'd0,
    CFG_START_COL  = 2'd1,
    CFG_START_LINE = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIZE_12 = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_24 = 2'd2,
    SIZE_14 = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    K_A12  = 3'd0,
    K_A16  = 3'd1,
    K_A24  = 3'd2,
    K_A14  = 3'd3,
    K_H16  = 3'd4,
    K_H24  = 3'd5,
    K_H14  = 3'd6,
    K_NONE = 3'd7
  } kind_e;

  localparam logic [19:0] BASE_A12 = 20'd0;
  localparam logic [19:0] BASE_A16 = BASE_A12 + 20'd1536;
  localparam logic [19:0] BASE_A24 = BASE_A16 + 20'd4096;
  localparam logic [19:0] BASE_H16 = BASE_A24 + 20'd12288;
  localparam logic [19:0] BASE_H24 = BASE_H16 + 20'd267616;
  localparam logic [19:0] BASE_H14 = 20'd784064;
  localparam logic [19:0] BASE_A14 = BASE_H14 + 20'd189504;

  localparam logic [7:0] HZ_LEAD   = 8'ha0;
  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam int         HZ_ROW    = 94;

  typedef struct packed {
    logic clr_wr;
    logic ld_in;
    logic chr_commit;
    logic out_load;
    logic rd_req;
    logic g_rd0;
    logic g_rd1;
    logic g_wr0;
    logic g_wr1;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic glyph_active;
    logic out_free;
  } sts_t;

  function automatic logic [4:0] kind_w(kind_e k);
    unique case (k)
      K_A12, K_A16, K_A14: kind_w = 5'd8;
      K_A24, K_H16:        kind_w = 5'd16;
      K_H24:               kind_w = 5'd24;
      K_H14:               kind_w = 5'd14;
      default:             kind_w = 5'd0;
    endcase
  endfunction

  function automatic logic [4:0] kind_h(kind_e k);
    unique case (k)
      K_A12:        kind_h = 5'd12;
      K_A16, K_H16: kind_h = 5'd16;
      K_A24, K_H24: kind_h = 5'd24;
      K_A14, K_H14: kind_h = 5'd14;
      default:      kind_h = 5'd0;
    endcase
  endfunction

  function automatic logic [6:0] kind_len(kind_e k);
    unique case (k)
      K_A12:   kind_len = 7'd12;
      K_A16:   kind_len = 7'd16;
      K_A24:   kind_len = 7'd48;
      K_A14:   kind_len = 7'd14;
      K_H16:   kind_len = 7'd32;
      K_H24:   kind_len = 7'd72;
      K_H14:   kind_len = 7'd28;
      default: kind_len = 7'd0;
    endcase
  endfunction

  function automatic logic [19:0] kind_base(kind_e k);
    unique case (k)
      K_A12:   kind_base = BASE_A12;
      K_A16:   kind_base = BASE_A16;
      K_A24:   kind_base = BASE_A24;
      K_A14:   kind_base = BASE_A14;
      K_H16:   kind_base = BASE_H16;
      K_H24:   kind_base = BASE_H24;
      K_H14:   kind_base = BASE_H14;
      default: kind_base = 20'd0;
    endcase
  endfunction

  // bytes per glyph line
  function automatic logic [1:0] kind_bpl(kind_e k);
    unique case (k)
      K_A12, K_A16, K_A14: kind_bpl = 2'd1;
      K_A24, K_H16, K_H14: kind_bpl = 2'd2;
      K_H24:               kind_bpl = 2'd3;
      default:             kind_bpl = 2'd0;
    endcase
  endfunction

endpackage

// ===== sv/gtr_ctrl.sv =====
// Sequencer of the glyph text renderer: clear pass, item decode, memory steps.
module gtr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [1:0]        op_i,
  input  gtr_pkg::sts_t     sts_i,
  output gtr_pkg::cmd_t     cmd_o
);

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_CHR_OUT = 9'b000000100,
    ST_RD_REQ  = 9'b000001000,
    ST_RD_OUT  = 9'b000010000,
    ST_GLY_RD0 = 9'b000100000,
    ST_GLY_RD1 = 9'b001000000,
    ST_GLY_WR0 = 9'b010000000,
    ST_GLY_WR1 = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.ld_in = 1'b1;
          unique case (gtr_pkg::op_e'(op_i))
            gtr_pkg::OP_CHAR:  state_d = ST_CHR_OUT;
            gtr_pkg::OP_GLYPH: state_d = sts_i.glyph_active ? ST_GLY_RD0 : ST_IDLE;
            gtr_pkg::OP_READ:  state_d = ST_RD_REQ;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHR_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.chr_commit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_RD_REQ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_GLY_RD0: begin
        cmd_o.g_rd0 = 1'b1;
        state_d     = ST_GLY_RD1;
      end
      ST_GLY_RD1: begin
        cmd_o.g_rd1 = 1'b1;
        state_d     = ST_GLY_WR0;
      end
      ST_GLY_WR0: begin
        cmd_o.g_wr0 = 1'b1;
        state_d     = ST_GLY_WR1;
      end
      ST_GLY_WR1: begin
        cmd_o.g_wr1 = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free) else $error("result loaded into full slot");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> !s_axis_tready) else $error("input taken during clear");
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.g_rd1 |=> cmd_o.g_wr0 ##1 cmd_o.g_wr1) else $error("glyph rmw broken");
`endif

endmodule

// ===== sv/gtr_datapath.sv =====
// Datapath of the glyph text renderer: layout, font address, framebuffer, result.
module gtr_datapath #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 72,
  parameter int CHAR_GAP      = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gtr_pkg::cmd_t cmd_i,
  output gtr_pkg::sts_t sts_o,
  input  logic [1:0]    op_i,
  input  logic [39:0]   in_data_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [6:0]    cfg_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   out_data_o
);

  localparam int RB          = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_BYTES = SCREEN_HEIGHT * RB;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int XW          = 14;
  localparam int CW          = 11;

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic [1:0]    size_q;
  logic [CW-1:0] crs_col_q, crs_line_q;
  logic [7:0]    wcol_q, wline_q;
  gtr_pkg::kind_e kind_q, ck_q;
  logic [4:0]    glc_q;
  logic [1:0]    lbc_q;
  logic [13:0]   idx_q;
  logic [1:0]    cbu_q;
  logic [7:0]    gdata_q;
  logic [XW-1:0] fidx_q;
  logic          fidx_ok_q;
  logic [AW:0]   clr_cnt_q;
  logic [7:0]    w0_q;
  logic          out_valid_q;
  logic [63:0]   out_q;

  // character decode at accept
  logic [7:0] c1, c2;
  logic       hz;
  gtr_pkg::kind_e k1;
  logic signed [15:0] d1, d2, idx1;

  assign c1 = in_data_i[7:0];
  assign c2 = in_data_i[15:8];
  assign hz = c1 > gtr_pkg::HZ_LEAD;
  assign d2 = $signed({8'd0, c2}) - 16'sd161;

  always_comb begin
    unique case (gtr_pkg::size_e'(size_q))
      gtr_pkg::SIZE_12: k1 = hz ? gtr_pkg::K_NONE : gtr_pkg::K_A12;
      gtr_pkg::SIZE_16: k1 = hz ? gtr_pkg::K_H16 : gtr_pkg::K_A16;
      gtr_pkg::SIZE_24: k1 = hz ? gtr_pkg::K_H24 : gtr_pkg::K_A24;
      default:          k1 = hz ? gtr_pkg::K_H14 : gtr_pkg::K_A14;
    endcase
    d1   = $signed({8'd0, c1}) - ((k1 == gtr_pkg::K_H16) ? 16'sd161 : 16'sd176);
    idx1 = 16'sd0;
    priority case (k1)
      gtr_pkg::K_A12, gtr_pkg::K_A16, gtr_pkg::K_A24: idx1 = $signed({8'd0, c1});
      gtr_pkg::K_A14: idx1 = $signed({8'd0, c1}) - 16'sd32;
      gtr_pkg::K_NONE: idx1 = 16'sd0;
      default: idx1 = 16'(16'(gtr_pkg::HZ_ROW) * d1) + d2;
    endcase
  end

  // layout and font address
  logic [CW-1:0] w, h, col, line, col_a, line_a;
  logic [20:0]   addr_sum;

  always_comb begin
    w     = CW'(gtr_pkg::kind_w(ck_q));
    h     = CW'(gtr_pkg::kind_h(ck_q));
    col_a = crs_col_q;
    line_a = crs_line_q;
    if (crs_col_q + w > CW'(SCREEN_WIDTH)) begin
      col_a  = '0;
      line_a = crs_line_q + h + CW'(CHAR_GAP);
    end
    col  = col_a;
    line = line_a;
    if (line_a + h > CW'(SCREEN_HEIGHT)) begin
      col  = '0;
      line = '0;
    end
    addr_sum = 21'(gtr_pkg::kind_base(ck_q))
             + 21'(idx_q) * 21'(gtr_pkg::kind_len(ck_q));
  end

  // glyph byte placement
  logic [1:0]  bpl;
  logic [3:0]  keep;
  logic [8:0]  x0, y;
  logic        y_ok;
  logic [15:0] span_m, span_v, col_m, m;
  logic [AW:0] a0, a1;
  logic [2:0]  s;
  logic [8:0]  xb;

  always_comb begin
    bpl  = gtr_pkg::kind_bpl(kind_q);
    keep = (kind_q == gtr_pkg::K_H14 && lbc_q + 2'd1 == bpl) ? 4'd6 : 4'd8;
    x0   = 9'(wcol_q) + {4'd0, lbc_q, 3'd0};
    y    = 9'(wline_q) + 9'(glc_q);
    y_ok = 32'(y) < SCREEN_HEIGHT;
    s    = x0[2:0];
    xb   = {x0[8:3], 3'd0};
    span_m = {8'hff << (4'd8 - keep), 8'h00} >> s;
    span_v = {~gdata_q, 8'h00} >> s;
    for (int i = 0; i < 16; i++) begin
      col_m[15-i] = (32'(xb) + i) < SCREEN_WIDTH;
    end
    m  = span_m & col_m;
    a0 = (AW+1)'(32'(y) * RB + 32'(x0[8:3]));
    a1 = a0 + 1'b1;
  end

  // memory port muxing
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q[AW-1:0];
    mem_wdata = gtr_pkg::FILL_BYTE;
    mem_re    = 1'b0;
    mem_raddr = fidx_q[AW-1:0];
    priority if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.g_wr0) begin
      mem_we    = y_ok && (|m[15:8]);
      mem_waddr = a0[AW-1:0];
      mem_wdata = (w0_q & ~m[15:8]) | (span_v[15:8] & m[15:8]);
    end else if (cmd_i.g_wr1) begin
      mem_we    = y_ok && (|m[7:0]);
      mem_waddr = a1[AW-1:0];
      mem_wdata = (rdata_q & ~m[7:0]) | (span_v[7:0] & m[7:0]);
    end else if (cmd_i.rd_req) begin
      mem_re = fidx_ok_q;
    end else if (cmd_i.g_rd0) begin
      mem_re    = 1'b1;
      mem_raddr = a0[AW-1:0];
    end else if (cmd_i.g_rd1) begin
      mem_re    = 1'b1;
      mem_raddr = a1[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      gdata_q   <= in_data_i[23:16];
      fidx_q    <= XW'(in_data_i[33:24]);
      fidx_ok_q <= 32'(in_data_i[33:24]) < STORE_BYTES;
      cbu_q     <= hz ? 2'd2 : 2'd1;
      idx_q     <= idx1[13:0];
      if (op_i == gtr_pkg::OP_CHAR)
        ck_q <= idx1[15] ? gtr_pkg::K_NONE : k1;
    end
    if (cmd_i.g_rd1) w0_q <= rdata_q;
    if (cmd_i.out_load) begin
      if (cmd_i.chr_commit) begin
        if (ck_q == gtr_pkg::K_NONE) begin
          out_q <= {8'd0, 1'b1, 7'd0, 6'd0, 7'd0, 6'd0, cbu_q, 7'd0, 20'd0};
        end else begin
          out_q <= {8'd0, 1'b0, 7'(line + h - 1'b1), 6'(col + w - 1'b1),
                    7'(line), 6'(col), cbu_q,
                    gtr_pkg::kind_len(ck_q), addr_sum[19:0]};
        end
      end else begin
        out_q <= {(fidx_ok_q ? rdata_q : 8'd0), 56'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= gtr_pkg::SIZE_14;
      crs_col_q   <= '0;
      crs_line_q  <= '0;
      wcol_q      <= '0;
      wline_q     <= '0;
      kind_q      <= gtr_pkg::K_NONE;
      glc_q       <= '0;
      lbc_q       <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) begin
        unique case (gtr_pkg::cfg_idx_e'(cfg_idx_i))
          gtr_pkg::CFG_FONT_SIZE:  size_q <= cfg_data_i[1:0];
          gtr_pkg::CFG_START_COL:  crs_col_q <= CW'(cfg_data_i);
          gtr_pkg::CFG_START_LINE: crs_line_q <= CW'(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.chr_commit) begin
        kind_q <= ck_q;
        glc_q  <= '0;
        lbc_q  <= '0;
        if (ck_q != gtr_pkg::K_NONE) begin
          wcol_q     <= col[7:0];
          wline_q    <= line[7:0];
          crs_col_q  <= col + w + CW'(CHAR_GAP);
          crs_line_q <= line;
        end
      end
      if (cmd_i.g_wr1) begin
        if (lbc_q + 2'd1 >= bpl) begin
          lbc_q <= '0;
          if (glc_q + 5'd1 >= gtr_pkg::kind_h(kind_q)) begin
            glc_q  <= '0;
            kind_q <= gtr_pkg::K_NONE;
          end else begin
            glc_q <= glc_q + 5'd1;
          end
        end else begin
          lbc_q <= lbc_q + 2'd1;
        end
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.clr_last     = 32'(clr_cnt_q) == STORE_BYTES - 1;
  assign sts_o.glyph_active = kind_q != gtr_pkg::K_NONE;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

`ifndef SYNTHESIS
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> 32'(mem_waddr) < STORE_BYTES) else $error("framebuffer write out of range");
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q != gtr_pkg::K_NONE |-> glc_q < gtr_pkg::kind_h(kind_q))
    else $error("glyph line past glyph height");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("stalled result dropped");
`endif

endmodule

// ===== sv/glyph_text_renderer.sv =====
// Top level of the glyph text renderer: sequencer plus datapath.
//
// Items enter on the s_axis channel, the kind of item in s_axis_tuser: a
// character (one or two code bytes), a glyph data byte, or a framebuffer read.
// Character and read items return one beat on m_axis; glyph bytes return none.
// A character result is loaded from ST_CHR_OUT, a read result from ST_RD_OUT after
// the ST_RD_REQ read; a glyph byte is a read-modify-write of two framebuffer
// bytes (ST_GLY_RD0, ST_GLY_RD1, ST_GLY_WR0, ST_GLY_WR1) in the framebuffer memory.
// The next item is taken once the current one is done, while the result beat
// may still wait in the output register. If that register is still full when
// the next result is ready, the block holds until the receiver takes the beat.
// After reset the framebuffer is filled with 0xff, one byte per cycle, over all
// SCREEN_HEIGHT * ceil(SCREEN_WIDTH/8) bytes (576 by default); no item is
// accepted meanwhile, configuration writes are taken at any time.
// Configuration is to be written by the user while idle (not enforced by the block):
// index 0 font size, 1 start column, 2 start line (the last two also move the cursor).
module glyph_text_renderer #(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 72,
  parameter int CHAR_GAP      = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // code_first[7:0], code_second[15:8], glyph_data[23:16], frame_index[33:24]
  input  logic [39:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // font_addr[19:0], glyph_len[26:20], code_bytes_used[28:27], win_left[34:29],
  // win_top[41:35], win_right[47:42], win_bottom[54:48], font_error[55],
  // frame_byte[63:56]
  output logic [63:0] m_axis_tdata
);

  gtr_pkg::cmd_t cmd;
  gtr_pkg::sts_t sts;

  gtr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_i          (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gtr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .CHAR_GAP      (CHAR_GAP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== bench/tb_glyph_text_renderer.sv =====
// Self-checking testbench of the glyph text renderer: streamed text, glyph and read beats.
module tb_glyph_text_renderer;

  localparam int ROW_BYTES   = 8;
  localparam int STORE_BYTES = 576;
  localparam int WD_LIMIT    = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  glyph_text_renderer i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  class render_scoreboard;
    int unsigned size_code, crs_col, crs_line, win_col, win_line;
    int unsigned kind, line_cnt, byte_cnt, bytes_left;
    logic [7:0]  frame[STORE_BYTES];
    logic [63:0] expected_q[$];
    int          errors;
    int          fw[8] = '{8, 8, 16, 8, 16, 24, 14, 0};
    int          fh[8] = '{12, 16, 24, 14, 16, 24, 14, 0};
    int          flen[8] = '{12, 16, 48, 14, 32, 72, 28, 0};
    int          flo[9] = '{0, 20, 27, 29, 35, 42, 48, 55, 56};
    int          fwd[9] = '{20, 7, 2, 6, 7, 6, 7, 1, 8};
    string       fname[9] = '{"font_addr", "glyph_len", "code_bytes_used", "win_left",
                              "win_top", "win_right", "win_bottom", "font_error",
                              "frame_byte"};

    function new();
      size_code = 3;
      crs_col = 0;
      crs_line = 0;
      win_col = 0;
      win_line = 0;
      kind = gtr_pkg::K_NONE;
      line_cnt = 0;
      byte_cnt = 0;
      bytes_left = 0;
      errors = 0;
      foreach (frame[i]) frame[i] = gtr_pkg::FILL_BYTE;
    endfunction

    function void write_reg(gtr_pkg::cfg_idx_e idx, int unsigned val);
      case (idx)
        gtr_pkg::CFG_FONT_SIZE:  size_code = val & 3;
        gtr_pkg::CFG_START_COL:  crs_col = val & 'h7f;
        gtr_pkg::CFG_START_LINE: crs_line = val & 'h7f;
        default: ;
      endcase
    endfunction

    function int unsigned base_of(int unsigned k);
      case (k)
        gtr_pkg::K_A12: return gtr_pkg::BASE_A12;
        gtr_pkg::K_A16: return gtr_pkg::BASE_A16;
        gtr_pkg::K_A24: return gtr_pkg::BASE_A24;
        gtr_pkg::K_A14: return gtr_pkg::BASE_A14;
        gtr_pkg::K_H16: return gtr_pkg::BASE_H16;
        gtr_pkg::K_H24: return gtr_pkg::BASE_H24;
        gtr_pkg::K_H14: return gtr_pkg::BASE_H14;
        default:        return 0;
      endcase
    endfunction

    function void render_char(int unsigned c1, int unsigned c2);
      logic [63:0] r;
      bit          hz;
      int          gidx;
      int unsigned w, h, col, line, addr;
      r = '0;
      hz = c1 > gtr_pkg::HZ_LEAD;
      r[28:27] = hz ? 2'd2 : 2'd1;
      case (gtr_pkg::size_e'(size_code[1:0]))
        gtr_pkg::SIZE_12: kind = hz ? gtr_pkg::K_NONE : gtr_pkg::K_A12;
        gtr_pkg::SIZE_16: kind = hz ? gtr_pkg::K_H16 : gtr_pkg::K_A16;
        gtr_pkg::SIZE_24: kind = hz ? gtr_pkg::K_H24 : gtr_pkg::K_A24;
        default:          kind = hz ? gtr_pkg::K_H14 : gtr_pkg::K_A14;
      endcase
      gidx = 0;
      if (kind <= gtr_pkg::K_A24) gidx = c1;
      else if (kind == gtr_pkg::K_A14) gidx = int'(c1) - 32;
      else if (kind == gtr_pkg::K_H16)
        gidx = gtr_pkg::HZ_ROW * (int'(c1) - 161) + (int'(c2) - 161);
      else if (kind != gtr_pkg::K_NONE)
        gidx = gtr_pkg::HZ_ROW * (int'(c1) - 160 - 16) + (int'(c2) - 161);
      if (gidx < 0) kind = gtr_pkg::K_NONE;
      line_cnt = 0;
      byte_cnt = 0;
      bytes_left = 0;
      if (kind == gtr_pkg::K_NONE) begin
        r[55] = 1'b1;
      end else begin
        w = fw[kind];
        h = fh[kind];
        col = crs_col;
        line = crs_line;
        if (col + w > 64) begin
          col = 0;
          line += h;
        end
        if (line + h > 72) begin
          line = 0;
          col = 0;
        end
        win_col = col;
        win_line = line;
        crs_col = col + w;
        crs_line = line;
        bytes_left = flen[kind];
        addr = base_of(kind) + gidx * flen[kind];
        r[19:0]  = addr[19:0];
        r[26:20] = 7'(flen[kind]);
        r[34:29] = 6'(col);
        r[41:35] = 7'(line);
        r[47:42] = 6'(col + w - 1);
        r[54:48] = 7'(line + h - 1);
      end
      expected_q.push_back(r);
    endfunction

    function void draw_byte(logic [7:0] d);
      int unsigned w, per_line, keep, x, y, a;
      if (kind == gtr_pkg::K_NONE) return;
      w = fw[kind];
      per_line = (w + 7) / 8;
      keep = (byte_cnt + 1 == per_line && (w % 8) != 0) ? w % 8 : 8;
      for (int k = 0; k < keep; k++) begin
        x = win_col + byte_cnt * 8 + k;
        y = win_line + line_cnt;
        if (x < 64 && y < 72) begin
          a = y * ROW_BYTES + x / 8;
          frame[a][7 - x % 8] = ~d[7 - k];
        end
      end
      bytes_left--;
      byte_cnt++;
      if (byte_cnt >= per_line) begin
        byte_cnt = 0;
        line_cnt++;
        if (line_cnt >= fh[kind]) begin
          line_cnt = 0;
          kind = gtr_pkg::K_NONE;
        end
      end
    endfunction

    function void note_input(gtr_pkg::op_e op, logic [39:0] d);
      logic [63:0] r;
      case (op)
        gtr_pkg::OP_CHAR:  render_char(d[7:0], d[15:8]);
        gtr_pkg::OP_GLYPH: draw_byte(d[23:16]);
        gtr_pkg::OP_READ: begin
          r = '0;
          if (d[33:24] < STORE_BYTES) r[63:56] = frame[d[33:24]];
          expected_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [63:0] act);
      logic [63:0] e, m;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        m = (64'd1 << fwd[i]) - 1;
        if (((e >> flo[i]) & m) != ((act >> flo[i]) & m)) begin
          $display("%0t: %s expected %0h actual %0h", $time, fname[i],
                   (e >> flo[i]) & m, (act >> flo[i]) & m);
          errors++;
        end
      end
    endfunction
  endclass

  render_scoreboard sb = new();
  int tx_gap_pct, rx_stall_pct;
  bit hold_req, hold_done;
  int hold_left, idle_cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [39:0] pack(int c1, int c2, int g, int fi);
    return {6'd0, fi[9:0], g[7:0], c2[7:0], c1[7:0]};
  endfunction

  task automatic send(gtr_pkg::op_e op, logic [39:0] d);
    if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, d);
  endtask

  task automatic send_char(int c1, int c2);
    send(gtr_pkg::OP_CHAR, pack(c1, c2, $urandom_range(255), $urandom_range(1023)));
  endtask

  task automatic send_glyph(int n);
    for (int i = 0; i < n; i++)
      send(gtr_pkg::OP_GLYPH, pack($urandom_range(255), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(1023)));
  endtask

  task automatic send_read(int fi);
    send(gtr_pkg::OP_READ, pack($urandom_range(255), $urandom_range(255),
                                $urandom_range(255), fi));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(gtr_pkg::cfg_idx_e idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[6:0];
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_char(output int n);
    int c1, c2;
    c1 = ($urandom_range(1)) ? $urandom_range('ha1, 'hff) : $urandom_range(0, 'ha0);
    c2 = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range('ha1, 'hfe);
    send_char(c1, c2);
    n = sb.bytes_left;
  endtask

  task automatic random_part(int items);
    int cnt, r, n;
    cnt = 0;
    while (cnt < items) begin
      r = $urandom_range(99);
      if (r < 60) begin
        random_char(n);
        send_glyph(n);
        send_read($urandom_range(STORE_BYTES - 1));
        cnt += n + 2;
      end else if (r < 70) begin
        random_char(n);
        n = (n > 0) ? $urandom_range(n - 1) : 0;
        send_glyph(n);
        cnt += n + 1;
      end else if (r < 85) begin
        send_read(($urandom_range(9) == 0) ? $urandom_range(1023)
                                           : $urandom_range(STORE_BYTES - 1));
        cnt++;
      end else if (r < 90) begin
        send(gtr_pkg::OP_NONE, pack($urandom_range(255), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(1023)));
      end else begin
        send_glyph(1);
      end
    end
  endtask

  initial begin
    int pct_tx[4] = '{0, 86, 0, 7};
    int pct_rx[4] = '{0, 0, 86, 7};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = gtr_pkg::CFG_FONT_SIZE;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = gtr_pkg::OP_CHAR;
    m_axis_tready = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config is the 14px set
    send_read(0);
    send_char('h00, 'h00);
    send_glyph(1);
    send_char('h20, 'h00);
    send_glyph(14);
    send_char('hff, 'hff);
    send_glyph(28);
    send_char('ha1, 'ha1);
    send(gtr_pkg::OP_NONE, pack('hff, 'hff, 'hff, 1023));
    send_char('hb0, 'ha1);
    send_glyph(5);
    send_char('ha0, 'h00);
    send_read(0);
    send_read(1);
    send_read(STORE_BYTES - 1);
    send_read(STORE_BYTES);
    send_read(1023);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      tx_gap_pct = pct_tx[ph % 4];
      rx_stall_pct = pct_rx[ph % 4];
      write_reg(gtr_pkg::CFG_FONT_SIZE, ph % 4);
      write_reg(gtr_pkg::CFG_START_COL,
                (ph == 1) ? 64 : (ph == 2) ? 0 : $urandom_range(64));
      write_reg(gtr_pkg::CFG_START_LINE,
                (ph == 1) ? 72 : (ph == 2) ? 0 : $urandom_range(72));
      if (ph == 0) hold_req = 1'b1;
      random_part(250);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
